/* hdl/assert_macros.svh */
// assertion macros shared by the sine/cosine series unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/scs_pkg.sv */
// shared types, constants and microprogram of the sine/cosine series unit
package scs_pkg;

  localparam int ANGLE_W    = 36;
  localparam int ANGLE_FRAC = 27;
  localparam int OUT_W      = 32;
  localparam int OUT_FRAC   = 30;

  // pi with 60 fraction bits, truncated
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  typedef logic [2:0] step_t;

  localparam step_t ST_IDLE = 3'd0;
  localparam step_t ST_RED  = 3'd1;
  localparam step_t ST_ISQ  = 3'd2;
  localparam step_t ST_INIT = 3'd3;
  localparam step_t ST_MRCP = 3'd4;
  localparam step_t ST_ACC  = 3'd5;
  localparam step_t ST_OUT  = 3'd6;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_RED,
    OP_ISQ,
    OP_INIT,
    OP_MRCP,
    OP_ACC,
    OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_NSTART,
    JC_OUTRANGE,
    JC_MORE
  } cond_t;

  typedef struct packed {
    op_t   op;
    logic  wait_done;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic start;
    logic negate;
  } mul_req_t;

  typedef struct packed {
    logic out_range;
    logic more;
  } dp_stat_t;

  // control store: one word per step
  function automatic ctrl_word_t ucode(input step_t step);
    ctrl_word_t w;
    unique case (step)
      ST_IDLE: w = '{OP_LOAD, 1'b0, JC_NSTART,   ST_IDLE};
      ST_RED:  w = '{OP_RED,  1'b0, JC_OUTRANGE, ST_RED};
      ST_ISQ:  w = '{OP_ISQ,  1'b0, JC_NEVER,    ST_IDLE};
      ST_INIT: w = '{OP_INIT, 1'b1, JC_NEVER,    ST_IDLE};
      ST_MRCP: w = '{OP_MRCP, 1'b1, JC_NEVER,    ST_IDLE};
      ST_ACC:  w = '{OP_ACC,  1'b1, JC_MORE,     ST_MRCP};
      ST_OUT:  w = '{OP_OUT,  1'b0, JC_ALWAYS,   ST_IDLE};
      default: w = '{OP_LOAD, 1'b0, JC_ALWAYS,   ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* hdl/scs_mult.sv */
// chunked sign-magnitude multiplier with floor rounding of the fraction bits
`include "assert_macros.svh"

module scs_mult
  import scs_pkg::*;
#(
  parameter int WORK_FRAC_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mul_req_t                        req,
  input  logic signed [WORK_FRAC_BITS+6:0] op_a,
  input  logic signed [WORK_FRAC_BITS+6:0] op_b,
  output logic                            done,
  output logic signed [WORK_FRAC_BITS+6:0] res
);

  localparam int WW   = WORK_FRAC_BITS + 7;
  localparam int MAGW = WW - 1;
  localparam int NCH  = (MAGW + 23) / 24;
  localparam int CW   = (MAGW + NCH - 1) / NCH;
  localparam int BW   = NCH * CW;
  localparam int KW   = $clog2(NCH);

  logic [MAGW-1:0]    ma_r;
  logic [BW-1:0]      mb_r;
  logic [MAGW-1:0]    acc_r;
  logic [BW-1:0]      lo_r;
  logic               pn_r;
  logic               sn_r;
  logic               run_r;
  logic               fin_r;
  logic               done_r;
  logic [KW-1:0]      k_r;
  logic signed [WW-1:0] res_r;

  logic [MAGW-1:0]    a_mag;
  logic [MAGW-1:0]    b_mag;
  logic [MAGW+CW-1:0] psum;
  logic [MAGW+BW-1:0] prod;
  logic [MAGW-1:0]    qf;
  logic               round_up;
  logic               cin;
  logic               last;

  assign a_mag = op_a[WW-1] ? MAGW'(-op_a) : MAGW'(op_a);
  assign b_mag = op_b[WW-1] ? MAGW'(-op_b) : MAGW'(op_b);
  assign last  = (k_r == KW'(NCH - 1));

  // one chunk of the multiplier operand per cycle, low chunk first
  assign psum = (MAGW+CW)'(acc_r) + (MAGW+CW)'(ma_r) * (MAGW+CW)'(mb_r[CW-1:0]);

  assign prod     = {acc_r, lo_r};
  assign qf       = prod[WORK_FRAC_BITS +: MAGW];
  assign round_up = pn_r & (|prod[WORK_FRAC_BITS-1:0]);
  // negative result: -(q + r) is ~q when r is set, else ~q + 1
  assign cin      = sn_r ? ~round_up : round_up;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= fin_r;
      fin_r  <= run_r & last;
      if (req.start) begin
        run_r <= 1'b1;
        k_r   <= '0;
      end else if (run_r) begin
        if (last) begin
          run_r <= 1'b0;
        end
        k_r <= k_r + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      ma_r  <= a_mag;
      mb_r  <= BW'(b_mag);
      acc_r <= '0;
      pn_r  <= op_a[WW-1] ^ op_b[WW-1];
      sn_r  <= op_a[WW-1] ^ op_b[WW-1] ^ req.negate;
    end else if (run_r) begin
      acc_r <= psum[MAGW+CW-1:CW];
      lo_r  <= {psum[CW-1:0], lo_r[BW-1:CW]};
      mb_r  <= mb_r >> CW;
    end
    if (fin_r) begin
      res_r <= (sn_r ? ~{1'b0, qf} : {1'b0, qf}) + WW'(cin);
    end
  end

  assign done = done_r;
  assign res  = res_r;

  `ASSERT_NXT(a_done_follows_fin, clk, rst_n, fin_r, done_r && !fin_r)
  `ASSERT_IMP(a_no_start_while_running, clk, rst_n, run_r, !req.start)

endmodule

/* hdl/scs_datapath.sv */
// angle registers, reduction adder, series accumulator and output clamp
`include "assert_macros.svh"

module scs_datapath
  import scs_pkg::*;
#(
  parameter int SERIES_TERMS   = 10,
  parameter int WORK_FRAC_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ctrl_word_t                       cw,
  input  logic signed [ANGLE_W-1:0]        in_angle,
  input  logic                             in_mode,
  input  logic                             mdone,
  input  logic signed [WORK_FRAC_BITS+6:0] mres,
  output mul_req_t                         mreq,
  output logic signed [WORK_FRAC_BITS+6:0] mop_a,
  output logic signed [WORK_FRAC_BITS+6:0] mop_b,
  output dp_stat_t                         stat,
  output logic                             out_strobe,
  output logic signed [OUT_W-1:0]          out_value
);

  localparam int WW    = WORK_FRAC_BITS + 7;
  localparam int XW    = WORK_FRAC_BITS + 9;
  localparam int CNTW  = $clog2(SERIES_TERMS + 1);
  localparam int NRCP  = 2 * SERIES_TERMS;
  localparam int JW    = $clog2(NRCP);
  localparam int XSHL  = (WORK_FRAC_BITS >= ANGLE_FRAC) ? WORK_FRAC_BITS - ANGLE_FRAC : 0;
  localparam int XSHR  = (WORK_FRAC_BITS <  ANGLE_FRAC) ? ANGLE_FRAC - WORK_FRAC_BITS : 0;
  localparam int EXW   = ANGLE_W + XSHL;
  localparam int SHR   = (WORK_FRAC_BITS >= OUT_FRAC) ? WORK_FRAC_BITS - OUT_FRAC : 0;
  localparam int SHL   = (WORK_FRAC_BITS <  OUT_FRAC) ? OUT_FRAC - WORK_FRAC_BITS : 0;
  localparam int EW    = WW + SHL;

  localparam logic signed [XW-1:0] PI_X     = XW'(PI_Q60 >> (60 - WORK_FRAC_BITS));
  localparam logic signed [XW-1:0] NEG_PI_X = -PI_X;
  localparam logic signed [XW-1:0] TWO_PI_X = XW'(PI_Q60 >> (59 - WORK_FRAC_BITS));
  localparam logic signed [WW-1:0] ONE_W    = WW'(64'd1 << WORK_FRAC_BITS);
  localparam logic signed [EW-1:0] OUT_ONE  = EW'(64'd1 << OUT_FRAC);
  localparam logic signed [EW-1:0] OUT_MONE = -OUT_ONE;

  logic signed [XW-1:0]   x_r;
  logic                   mode_r;
  logic signed [WW-1:0]   x2_r;
  logic signed [WW-1:0]   sum_r;
  logic [JW-1:0]          j_r;
  logic [CNTW-1:0]        cnt_r;
  logic                   out_strobe_r;
  logic signed [OUT_W-1:0] out_value_r;

  logic signed [WW-1:0]   rcp_tab [NRCP];
  logic signed [XW-1:0]   x_conv;
  logic signed [WW-1:0]   x_w;
  logic                   gt_pi;
  logic                   lt_npi;
  logic                   more;
  logic signed [EW-1:0]   sum_ext;
  logic signed [EW-1:0]   sum_sh;
  logic signed [EW-1:0]   sum_cl;

  // reciprocals of j*(j+1) for the series factors
  for (genvar g = 0; g < NRCP; g++) begin : g_rcp
    localparam logic [63:0] RV =
      (64'd1 << WORK_FRAC_BITS) / 64'((g == 0) ? 1 : g * (g + 1));
    assign rcp_tab[g] = WW'(RV);
  end

  assign x_conv = XW'((EXW'(in_angle) <<< XSHL) >>> XSHR);
  assign x_w    = WW'(x_r);
  assign gt_pi  = (x_r > PI_X);
  assign lt_npi = (x_r < NEG_PI_X);
  assign more   = (cnt_r != CNTW'(1));

  assign stat.out_range = gt_pi | lt_npi;
  assign stat.more      = more;

  assign sum_ext = EW'(sum_r);
  assign sum_sh  = (sum_ext <<< SHL) >>> SHR;

  always_comb begin
    priority if (sum_sh > OUT_ONE) begin
      sum_cl = OUT_ONE;
    end else if (sum_sh < OUT_MONE) begin
      sum_cl = OUT_MONE;
    end else begin
      sum_cl = sum_sh;
    end
  end

  // multiplier requests; the previous product is forwarded as an operand
  always_comb begin
    mreq  = '0;
    mop_a = x_w;
    mop_b = x_w;
    unique case (cw.op)
      OP_ISQ: begin
        mreq.start = 1'b1;
      end
      OP_INIT: begin
        mreq.start = mdone;
        mop_a      = mode_r ? ONE_W : x_w;
        mop_b      = mres;
      end
      OP_MRCP: begin
        mreq.start  = mdone;
        mreq.negate = 1'b1;
        mop_a       = mres;
        mop_b       = rcp_tab[j_r];
      end
      OP_ACC: begin
        mreq.start = mdone & more;
        mop_a      = mres;
        mop_b      = x2_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (cw.op == OP_OUT);
    end
  end

  always_ff @(posedge clk) begin
    unique case (cw.op)
      OP_LOAD: begin
        x_r    <= x_conv;
        mode_r <= in_mode;
      end
      OP_RED: begin
        if (gt_pi) begin
          x_r <= x_r - TWO_PI_X;
        end else if (lt_npi) begin
          x_r <= x_r + TWO_PI_X;
        end
      end
      OP_INIT: begin
        if (mdone) begin
          x2_r  <= mres;
          sum_r <= mode_r ? ONE_W : x_w;
          j_r   <= mode_r ? JW'(1) : JW'(2);
          cnt_r <= mode_r ? CNTW'(SERIES_TERMS) : CNTW'(SERIES_TERMS - 1);
        end
      end
      OP_ACC: begin
        if (mdone) begin
          sum_r <= sum_r + mres;
          j_r   <= j_r + JW'(2);
          cnt_r <= cnt_r - CNTW'(1);
        end
      end
      OP_OUT: begin
        out_value_r <= OUT_W'(sum_cl);
      end
      default: begin
      end
    endcase
  end

  assign out_strobe = out_strobe_r;
  assign out_value  = out_value_r;

  `ASSERT_IMP(a_reduced_before_square, clk, rst_n, cw.op == OP_ISQ, !stat.out_range)
  `ASSERT_NXT(a_strobe_one_cycle, clk, rst_n, out_strobe_r, !out_strobe_r)

endmodule

/* hdl/scs_sequencer.sv */
// step counter over the control store, with wait-for-product and jumps
`include "assert_macros.svh"

module scs_sequencer
  import scs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       mdone,
  input  dp_stat_t   stat,
  output ctrl_word_t cw,
  output logic       busy
);

  step_t step_r;
  step_t step_nxt;
  logic  take;

  assign cw   = ucode(step_r);
  assign busy = (step_r != ST_IDLE);

  always_comb begin
    unique case (cw.cond)
      JC_NEVER:    take = 1'b0;
      JC_ALWAYS:   take = 1'b1;
      JC_NSTART:   take = ~start;
      JC_OUTRANGE: take = stat.out_range;
      JC_MORE:     take = stat.more;
      default:     take = 1'b0;
    endcase
  end

  always_comb begin
    priority if (cw.wait_done && !mdone) begin
      step_nxt = step_r;
    end else if (take) begin
      step_nxt = cw.target;
    end else begin
      step_nxt = step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  `ASSERT_NXT(a_accept_makes_busy, clk, rst_n, start && !busy, step_r == ST_RED)

endmodule

/* hdl/sine_cosine_series_unit.sv */
// top level of the fixed-point sine/cosine series unit
//
// Command interface: an angle (radians, 27 fraction bits) and a mode bit
// (0 sine, 1 cosine) transfer at a rising edge where start is high and busy
// is low. One result per item: out_value (30 fraction bits, clamped to
// plus or minus one) is valid for exactly one cycle while out_strobe is
// high; the receiver cannot hold it off, so it must take it then.
// A small control store steps a shared datapath: the angle is reduced into
// [-pi, pi] one 2*pi step per cycle, up to 41 steps for the full angle
// range; then each series term takes two products from one chunked
// multiplier of C = ceil((WORK_FRAC_BITS+6)/24) partial-product chunks.
// The series adds SERIES_TERMS terms to one for cosine and SERIES_TERMS-1
// terms to the angle for sine.
// busy drops in the cycle the strobe is shown, so a new item can transfer
// then: one item in flight.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// any item in flight without a result.
module sine_cosine_series_unit
  import scs_pkg::*;
#(
  parameter int SERIES_TERMS   = 10,
  parameter int WORK_FRAC_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [ANGLE_W-1:0] in_angle,
  input  logic                      in_mode,
  output logic                      out_strobe,
  output logic signed [OUT_W-1:0]   out_value
);

  localparam int WW = WORK_FRAC_BITS + 7;

  ctrl_word_t           cw;
  dp_stat_t             stat;
  mul_req_t             mreq;
  logic signed [WW-1:0] mop_a;
  logic signed [WW-1:0] mop_b;
  logic signed [WW-1:0] mres;
  logic                 mdone;

  scs_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mdone (mdone),
    .stat  (stat),
    .cw    (cw),
    .busy  (busy)
  );

  scs_datapath #(
    .SERIES_TERMS   (SERIES_TERMS),
    .WORK_FRAC_BITS (WORK_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cw         (cw),
    .in_angle   (in_angle),
    .in_mode    (in_mode),
    .mdone      (mdone),
    .mres       (mres),
    .mreq       (mreq),
    .mop_a      (mop_a),
    .mop_b      (mop_b),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_value  (out_value)
  );

  scs_mult #(
    .WORK_FRAC_BITS (WORK_FRAC_BITS)
  ) u_mult (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .op_a  (mop_a),
    .op_b  (mop_b),
    .done  (mdone),
    .res   (mres)
  );

endmodule
